// File: sv/vhd_pkg.sv
`timescale 1ns / 1ps
// vhd_pkg: widths, angle constants, arctangent table and side-band struct
// for the vector heading pipeline; depends on nothing

package vhd_pkg;

	localparam int COORD_WIDTH   = 16;
	localparam int CORDIC_STAGES = 18;
	localparam int GUARD_BITS    = 16;
	localparam int ANGLE_FRAC    = 16;

	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int X_W     = DIFF_W + GUARD_BITS + 3;
	localparam int Z_W     = 25;
	localparam int HEAD_W  = 17;
	localparam int IDX_W   = 5;
	localparam int NSTAGE  = CORDIC_STAGES + 3;

	localparam logic [HEAD_W-1:0] H_QUARTER = HEAD_W'(90 * 256);
	localparam logic [HEAD_W-1:0] H_HALF    = HEAD_W'(180 * 256);
	localparam logic [HEAD_W-1:0] H_THREEQ  = HEAD_W'(270 * 256);
	localparam logic [HEAD_W-1:0] H_FULL    = HEAD_W'(360 * 256);

	localparam logic signed [Z_W-1:0] Z_LIM   = Z_W'(90 << ANGLE_FRAC);
	localparam logic signed [Z_W-1:0] Z_ROUND = Z_W'(128);

	// atan(2^-i) in degrees, 16 fractional bits
	localparam logic signed [Z_W-1:0] ATAN_DEG [32] = '{
		Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945),
		Z_W'(234379), Z_W'(117304), Z_W'(58666), Z_W'(29335),
		Z_W'(14668), Z_W'(7334), Z_W'(3667), Z_W'(1833),
		Z_W'(917), Z_W'(458), Z_W'(229), Z_W'(115),
		Z_W'(57), Z_W'(29), Z_W'(14), Z_W'(7),
		Z_W'(4), Z_W'(2), Z_W'(1), Z_W'(0),
		Z_W'(0), Z_W'(0), Z_W'(0), Z_W'(0),
		Z_W'(0), Z_W'(0), Z_W'(0), Z_W'(0)
	};

	typedef struct packed {
		logic              special;
		logic [HEAD_W-1:0] fix_heading;
		logic              dx_neg;
		logic              dy_neg;
	} side_t;

endpackage

// File: sv/vector_heading_degrees_core.sv
`timescale 1ns / 1ps
// vector_heading_degrees_core: top level of the heading pipeline
// depends on vhd_pkg, vhd_prep, vhd_cordic_stage and vhd_place
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | begin_x, begin_y, end_x, end_y (s16)
//  out     | out_valid / out_ready| heading (u17, 1/256 degree)
//
// one request per cycle unless the output stalls; two prep stages, one
// register per cordic iteration and one output stage; the cordic iteration
// count sets the depth. each stage holds a valid bit and loads when empty or
// when the stage after it moves, so bubbles collapse and a stalled output
// only holds the stages that are full. reset clears the valid bits only.

module vector_heading_degrees_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [vhd_pkg::COORD_WIDTH-1:0] begin_x,
	input  logic signed [vhd_pkg::COORD_WIDTH-1:0] begin_y,
	input  logic signed [vhd_pkg::COORD_WIDTH-1:0] end_x,
	input  logic signed [vhd_pkg::COORD_WIDTH-1:0] end_y,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [vhd_pkg::HEAD_W-1:0]             heading
);

	localparam int N  = vhd_pkg::CORDIC_STAGES;
	localparam int NS = vhd_pkg::NSTAGE;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] ld;

	logic signed [vhd_pkg::X_W-1:0] x_c [N+1];
	logic signed [vhd_pkg::X_W-1:0] y_c [N+1];
	logic signed [vhd_pkg::Z_W-1:0] z_c [N+1];
	vhd_pkg::side_t                 side_c [N+1];

	// a stage may load when it is empty or its contents move on
	always_comb begin
		ld[NS-1] = !vld_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--)
			ld[k] = !vld_q[k] || ld[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++)
				if (ld[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = vld_q[NS-1];

	vhd_prep u_prep (
		.clk     (clk),
		.ld1     (ld[0]),
		.ld2     (ld[1]),
		.begin_x (begin_x),
		.begin_y (begin_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.x       (x_c[0]),
		.y       (y_c[0]),
		.side    (side_c[0])
	);

	assign z_c[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_cordic
		vhd_cordic_stage u_stage (
			.clk     (clk),
			.ld      (ld[k+2]),
			.idx     (vhd_pkg::IDX_W'(k)),
			.x_in    (x_c[k]),
			.y_in    (y_c[k]),
			.z_in    (z_c[k]),
			.side_in (side_c[k]),
			.x       (x_c[k+1]),
			.y       (y_c[k+1]),
			.z       (z_c[k+1]),
			.side    (side_c[k+1])
		);
	end

	vhd_place u_place (
		.clk     (clk),
		.ld      (ld[NS-1]),
		.z_in    (z_c[N]),
		.side_in (side_c[N]),
		.heading (heading)
	);

	// an empty output stage leaves the whole pipe free to take a request
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with empty output stage");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading < vhd_pkg::H_FULL)
		else $error("heading not below a full turn");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted request not captured in first stage");

	a_out_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NS-1] && !out_ready && vld_q[NS-2] |=> vld_q[NS-2])
		else $error("stage ahead of stalled output lost its request");

endmodule

// File: sv/vhd_prep.sv
`timescale 1ns / 1ps
// vhd_prep: first two stages; coordinate deltas, then magnitudes, axis
// cases and the cordic start vector; uses vhd_pkg

module vhd_prep (
	input  logic                                 clk,
	input  logic                                 ld1,
	input  logic                                 ld2,
	input  logic signed [vhd_pkg::COORD_WIDTH-1:0] begin_x,
	input  logic signed [vhd_pkg::COORD_WIDTH-1:0] begin_y,
	input  logic signed [vhd_pkg::COORD_WIDTH-1:0] end_x,
	input  logic signed [vhd_pkg::COORD_WIDTH-1:0] end_y,
	output logic signed [vhd_pkg::X_W-1:0]       x,
	output logic signed [vhd_pkg::X_W-1:0]       y,
	output vhd_pkg::side_t                       side
);

	logic signed [vhd_pkg::DIFF_W-1:0] dx_s1, dy_s1;
	logic [vhd_pkg::DIFF_W-1:0]        ax, ay;
	vhd_pkg::side_t                    side_d;

	always_ff @(posedge clk) begin
		if (ld1) begin
			dx_s1 <= vhd_pkg::DIFF_W'(end_x) - vhd_pkg::DIFF_W'(begin_x);
			dy_s1 <= vhd_pkg::DIFF_W'(end_y) - vhd_pkg::DIFF_W'(begin_y);
		end
	end

	always_comb begin
		ax = dx_s1[vhd_pkg::DIFF_W-1] ? vhd_pkg::DIFF_W'(-dx_s1) : vhd_pkg::DIFF_W'(dx_s1);
		ay = dy_s1[vhd_pkg::DIFF_W-1] ? vhd_pkg::DIFF_W'(-dy_s1) : vhd_pkg::DIFF_W'(dy_s1);
		side_d.dx_neg = dx_s1[vhd_pkg::DIFF_W-1];
		side_d.dy_neg = dy_s1[vhd_pkg::DIFF_W-1];
		side_d.special = 1'b1;
		side_d.fix_heading = '0;
		if (dx_s1 == '0) begin
			side_d.fix_heading = side_d.dy_neg ? vhd_pkg::H_HALF : '0;
		end else if (dy_s1 == '0) begin
			side_d.fix_heading = side_d.dx_neg ? vhd_pkg::H_THREEQ : vhd_pkg::H_QUARTER;
		end else begin
			side_d.special = 1'b0;
		end
	end

	// x starts from |dy| and y from |dx|: the angle is atan(|dx|/|dy|)
	always_ff @(posedge clk) begin
		if (ld2) begin
			x    <= vhd_pkg::X_W'(ay) << vhd_pkg::GUARD_BITS;
			y    <= vhd_pkg::X_W'(ax) << vhd_pkg::GUARD_BITS;
			side <= side_d;
		end
	end

endmodule

// File: sv/vhd_cordic_stage.sv
`timescale 1ns / 1ps
// vhd_cordic_stage: one registered cordic vectoring iteration;
// uses the arctangent table of vhd_pkg

module vhd_cordic_stage (
	input  logic                              clk,
	input  logic                              ld,
	input  logic [vhd_pkg::IDX_W-1:0]         idx,
	input  logic signed [vhd_pkg::X_W-1:0]    x_in,
	input  logic signed [vhd_pkg::X_W-1:0]    y_in,
	input  logic signed [vhd_pkg::Z_W-1:0]    z_in,
	input  vhd_pkg::side_t                    side_in,
	output logic signed [vhd_pkg::X_W-1:0]    x,
	output logic signed [vhd_pkg::X_W-1:0]    y,
	output logic signed [vhd_pkg::Z_W-1:0]    z,
	output vhd_pkg::side_t                    side
);

	logic signed [vhd_pkg::X_W-1:0] xs, ys;
	logic signed [vhd_pkg::Z_W-1:0] ang;

	// idx is tied to a constant per instance, so the shifts are wiring
	assign xs  = x_in >>> idx;
	assign ys  = y_in >>> idx;
	assign ang = vhd_pkg::ATAN_DEG[idx];

	always_ff @(posedge clk) begin
		if (ld) begin
			if (!y_in[vhd_pkg::X_W-1]) begin
				x <= x_in + ys;
				y <= y_in - xs;
				z <= z_in + ang;
			end else begin
				x <= x_in - ys;
				y <= y_in + xs;
				z <= z_in - ang;
			end
			side <= side_in;
		end
	end

endmodule

// File: sv/vhd_place.sv
`timescale 1ns / 1ps
// vhd_place: output stage; clamps and rounds the cordic angle, places it in
// its quadrant and applies the axis cases; uses vhd_pkg

module vhd_place (
	input  logic                              clk,
	input  logic                              ld,
	input  logic signed [vhd_pkg::Z_W-1:0]    z_in,
	input  vhd_pkg::side_t                    side_in,
	output logic [vhd_pkg::HEAD_W-1:0]        heading
);

	logic signed [vhd_pkg::Z_W-1:0] zc, zr;
	logic [vhd_pkg::HEAD_W-1:0]     phi, h;

	always_comb begin
		zc = z_in;
		if (z_in[vhd_pkg::Z_W-1])
			zc = '0;
		else if (z_in > vhd_pkg::Z_LIM)
			zc = vhd_pkg::Z_LIM;
		zr  = zc + vhd_pkg::Z_ROUND;
		phi = vhd_pkg::HEAD_W'(zr >>> 8);
		case ({side_in.dx_neg, side_in.dy_neg})
			2'b00:   h = phi;
			2'b01:   h = vhd_pkg::H_HALF - phi;
			2'b11:   h = vhd_pkg::H_HALF + phi;
			default: h = vhd_pkg::H_FULL - phi;
		endcase
		// a heading that rounds to a full turn wraps to zero
		if (h >= vhd_pkg::H_FULL)
			h = h - vhd_pkg::H_FULL;
		if (side_in.special)
			h = side_in.fix_heading;
	end

	always_ff @(posedge clk) begin
		if (ld)
			heading <= h;
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// testbench: randomized check of vector_heading_degrees_core against a built-in heading predictor
// depends on vhd_pkg and the core; driver, receiver and monitor run as clocked always blocks

module testbench;

	localparam int CW = vhd_pkg::COORD_WIDTH;
	localparam int HW = vhd_pkg::HEAD_W;

	localparam longint QUARTER_TURN       = 90 * 256;
	localparam longint HALF_TURN          = 180 * 256;
	localparam longint THREE_QUARTER_TURN = 270 * 256;
	localparam longint FULL_TURN          = 360 * 256;
	localparam longint ANGLE_CAP_Q16      = longint'(90) << 16;

	localparam int PIPE_LATENCY = 21;
	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASE_PAIRS  = 282;

	// atan(2^-i) in degrees, 16 fractional bits
	localparam longint ARCTAN_Q16 [32] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0,
		0, 0, 0, 0, 0, 0, 0, 0
	};

	typedef struct {
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ey;
	} point_pair_t;

	typedef struct {
		logic [HW-1:0] heading;
		point_pair_t   pair;
	} heading_expect_t;

	typedef enum int {
		PAIR_ANY, PAIR_NEAR, PAIR_AXIS, PAIR_STEEP, PAIR_DIAG, PAIR_EXTREME
	} pair_kind_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic signed [CW-1:0] begin_x   = '0;
	logic signed [CW-1:0] begin_y   = '0;
	logic signed [CW-1:0] end_x     = '0;
	logic signed [CW-1:0] end_y     = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [HW-1:0]        heading;

	point_pair_t     pair_q[$];
	heading_expect_t heading_q[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit sender_hold    = 1'b0;
	int fail_count     = 0;
	int sent_count     = 0;
	int axis_count     = 0;
	int checked_count  = 0;
	int quiet_cycles   = 0;

	vector_heading_degrees_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.begin_x   (begin_x),
		.begin_y   (begin_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.heading   (heading)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [HW-1:0] heading_of(point_pair_t p);
		longint dx, dy, x, y, z, xs, ys, phi, h;
		int i;
		dx = longint'(p.ex) - longint'(p.bx);
		dy = longint'(p.ey) - longint'(p.by);
		if (dx == 0) begin
			h = (dy >= 0) ? 0 : HALF_TURN;
		end else if (dy == 0) begin
			h = (dx > 0) ? QUARTER_TURN : THREE_QUARTER_TURN;
		end else begin
			// vectoring on (|dy|, |dx|) gives the angle away from the y axis
			x = (dy < 0 ? -dy : dy) <<< vhd_pkg::GUARD_BITS;
			y = (dx < 0 ? -dx : dx) <<< vhd_pkg::GUARD_BITS;
			z = 0;
			for (i = 0; i < vhd_pkg::CORDIC_STAGES; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + ARCTAN_Q16[i & 31];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - ARCTAN_Q16[i & 31];
				end
			end
			if (z < 0)
				z = 0;
			if (z > ANGLE_CAP_Q16)
				z = ANGLE_CAP_Q16;
			phi = (z + 128) >>> 8;
			if (dx > 0 && dy > 0)
				h = phi;
			else if (dx > 0)
				h = HALF_TURN - phi;
			else if (dy < 0)
				h = HALF_TURN + phi;
			else
				h = FULL_TURN - phi;
		end
		if (h >= FULL_TURN)
			h = h - FULL_TURN;
		return HW'(h);
	endfunction

	function automatic point_pair_t make_pair(int bx, int by, int ex, int ey);
		point_pair_t p;
		p.bx = CW'(bx);
		p.by = CW'(by);
		p.ex = CW'(ex);
		p.ey = CW'(ey);
		return p;
	endfunction

	function automatic point_pair_t random_pair();
		point_pair_t p;
		pair_kind_t  kind;
		int          roll;
		int          d;
		int          picks [5];
		picks = '{-32768, -1, 0, 1, 32767};
		roll = $urandom_range(0, 8);
		kind = (roll < 4) ? PAIR_ANY : pair_kind_t'(roll - 3);
		p.bx = CW'($urandom);
		p.by = CW'($urandom);
		p.ex = CW'($urandom);
		p.ey = CW'($urandom);
		case (kind)
			PAIR_NEAR: begin
				p.ex = CW'(int'(p.bx) + int'($urandom_range(0, 128)) - 64);
				p.ey = CW'(int'(p.by) + int'($urandom_range(0, 128)) - 64);
			end
			PAIR_AXIS: begin
				if ($urandom_range(0, 1))
					p.ex = p.bx;
				else
					p.ey = p.by;
			end
			PAIR_STEEP: begin
				// a tiny dx against a long dy lands next to the y axis
				p.ex = CW'(int'(p.bx) + int'($urandom_range(0, 6)) - 3);
			end
			PAIR_DIAG: begin
				d = $urandom_range(1, 32767);
				p.ex = CW'(int'(p.bx) + ($urandom_range(0, 1) ? d : -d));
				p.ey = CW'(int'(p.by) + ($urandom_range(0, 1) ? d : -d));
			end
			PAIR_EXTREME: begin
				p.bx = CW'(picks[$urandom_range(0, 4)]);
				p.by = CW'(picks[$urandom_range(0, 4)]);
				p.ex = CW'(picks[$urandom_range(0, 4)]);
				p.ey = CW'(picks[$urandom_range(0, 4)]);
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [HW-1:0] got,
			input heading_expect_t want);
		$display("%0t ns: %s: got %0d expected %0d for (%0d,%0d) -> (%0d,%0d)", $realtime,
			what, got, want.heading, want.pair.bx, want.pair.by, want.pair.ex, want.pair.ey);
		fail_count++;
	endtask

	task automatic queue_pair(input point_pair_t p);
		pair_q = {pair_q, p};
	endtask

	task automatic wait_results_done();
		while (in_valid || heading_q.size() != 0)
			@(negedge clk);
	endtask

	// request driver
	always @(posedge clk) begin : drive_pairs
		point_pair_t nxt;
		heading_expect_t want;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				want.pair.bx = begin_x;
				want.pair.by = begin_y;
				want.pair.ex = end_x;
				want.pair.ey = end_y;
				want.heading = heading_of(want.pair);
				heading_q = {heading_q, want};
				sent_count++;
				if (begin_x == end_x || begin_y == end_y)
					axis_count++;
			end
			if (!in_valid || in_ready) begin
				if (pair_q.size() != 0 && !sender_hold &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pair_q.pop_front();
					in_valid <= 1'b1;
					begin_x  <= nxt.bx;
					begin_y  <= nxt.by;
					end_x    <= nxt.ex;
					end_y    <= nxt.ey;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// result monitor and watchdog
	always @(posedge clk) begin : watch_headings
		heading_expect_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (heading_q.size() == 0) begin
					want.heading = '0;
					want.pair = make_pair(0, 0, 0, 0);
					report_mismatch("heading with no request pending", heading, want);
				end else begin
					want = heading_q.pop_front();
					checked_count++;
					if (heading !== want.heading)
						report_mismatch("heading mismatch", heading, want);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t ns: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	initial begin : run_phases
		int phase;
		int n;
		int send_pct [4];
		int recv_pct [4];
		send_pct = '{0, 51, 0, 21};
		recv_pct = '{0, 0, 51, 21};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// axis cases, quadrants, coordinate extremes and the full-turn wrap
		queue_pair(make_pair(0, 0, 0, 0));
		queue_pair(make_pair(0, 0, 0, 100));
		queue_pair(make_pair(0, 0, 0, -100));
		queue_pair(make_pair(0, 0, 100, 0));
		queue_pair(make_pair(0, 0, -100, 0));
		queue_pair(make_pair(0, 0, 100, 100));
		queue_pair(make_pair(0, 0, 100, -100));
		queue_pair(make_pair(0, 0, -100, -100));
		queue_pair(make_pair(0, 0, -100, 100));
		queue_pair(make_pair(-32768, -32768, 32767, 32767));
		queue_pair(make_pair(32767, 32767, -32768, -32768));
		queue_pair(make_pair(-32768, 32767, 32767, -32768));
		queue_pair(make_pair(32767, -32768, -32768, 32767));
		queue_pair(make_pair(0, -32768, -1, 32767));
		queue_pair(make_pair(0, -32768, 1, 32767));
		queue_pair(make_pair(-32768, 0, 32767, 1));
		queue_pair(make_pair(32767, 0, -32768, -1));
		queue_pair(make_pair(0, 32767, -1, -32768));
		queue_pair(make_pair(5, 5, 5, 5));
		queue_pair(make_pair(-32768, -32768, -32768, -32768));
		queue_pair(make_pair(32767, 32767, 32767, 32767));
		queue_pair(make_pair(-1, -1, 0, 0));
		queue_pair(make_pair(0, 0, 1, 2));
		queue_pair(make_pair(0, 0, 32767, 1));
		queue_pair(make_pair(0, 0, 1, -32768));

		for (phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			send_idle_pct  = send_pct[phase];
			recv_stall_pct = recv_pct[phase];
			for (n = 0; n < PHASE_PAIRS; n++)
				queue_pair(random_pair());
			if (phase == 2) begin
				// hold the sender mid-phase until the pipe has emptied
				while (pair_q.size() > PHASE_PAIRS / 2)
					@(negedge clk);
				sender_hold = 1'b1;
				wait_results_done();
				sender_hold = 1'b0;
			end
			while (pair_q.size() != 0)
				@(negedge clk);
			wait_results_done();
		end

		repeat (2 * PIPE_LATENCY + 8) @(posedge clk);
		@(negedge clk);
		if (heading_q.size() != 0) begin
			$display("%0d expected headings never arrived", heading_q.size());
			fail_count++;
		end
		$display("sent %0d point pairs (%0d on an axis) through four idling phases",
			sent_count, axis_count);
		$display("checked %0d headings, %0d mismatches", checked_count, fail_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
sv/vhd_pkg.sv
sv/vhd_prep.sv
sv/vhd_cordic_stage.sv
sv/vhd_place.sv
sv/vector_heading_degrees_core.sv
bench/testbench.sv
